// ----- src/sfcp_pkg.sv -----
// shared types and constants of the spi flash command planner
package sfcp_pkg;

  // request codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_SECTOR   = 3'd2,
    OP_CHIP     = 3'd3,
    OP_PWR_DOWN = 3'd4,
    OP_WAKE     = 3'd5,
    OP_READ_ID  = 3'd6,
    OP_WR_DIS   = 3'd7
  } op_e;

  // spi instruction bytes
  localparam logic [7:0] CmdWrDis  = 8'h04;
  localparam logic [7:0] CmdRead   = 8'h03;
  localparam logic [7:0] CmdPage   = 8'h02;
  localparam logic [7:0] CmdSector = 8'h20;
  localparam logic [7:0] CmdChip   = 8'hC7;
  localparam logic [7:0] CmdPwrDn  = 8'hB9;
  localparam logic [7:0] CmdWake   = 8'hAB;

  // data direction codes
  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirWrite = 2'd1;
  localparam logic [1:0] DirRead  = 2'd2;

  localparam int unsigned AddrW = 24;
  localparam int unsigned LenW  = 14;

  // planner states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture a new request
    logic emit;  // form the next descriptor into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic last_desc;  // the descriptor now being formed ends the request
  } dp_status_t;

  // one transaction descriptor
  typedef struct packed {
    logic             last;
    logic             poll_after;
    logic             poll_before;
    logic             enable_first;
    logic [1:0]       data_direction;
    logic [LenW-1:0]  data_count;
    logic [1:0]       dummy_count;
    logic             has_address;
    logic [AddrW-1:0] target_address;
    logic [7:0]       command_byte;
  } desc_t;

endpackage

// ----- src/sfcp_ctrl.sv -----
// request sequencing state machine of the spi flash command planner
module sfcp_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_ready_o,
  input  sfcp_pkg::dp_status_t    status_i,
  output sfcp_pkg::ctrl_cmd_t     cmd_o
);

  sfcp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfcp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfcp_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = sfcp_pkg::ST_EMIT;
      end
      sfcp_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.last_desc) state_d = sfcp_pkg::ST_IDLE;
      end
      default: state_d = sfcp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      sfcp_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      sfcp_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/sfcp_dp.sv -----
// request registers, page split arithmetic and output register
module sfcp_dp #(
  parameter int unsigned PAGE_BYTES = 256,
  parameter int unsigned MAX_LEN    = 8192
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfcp_pkg::ctrl_cmd_t               cmd_i,
  output sfcp_pkg::dp_status_t              status_o,
  input  sfcp_pkg::op_e                     req_op_i,
  input  logic [sfcp_pkg::AddrW-1:0]        req_addr_i,
  input  logic [sfcp_pkg::LenW-1:0]         req_len_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sfcp_pkg::desc_t                   out_desc_o
);

  localparam int unsigned PageW = $clog2(PAGE_BYTES);
  localparam int unsigned WideW = sfcp_pkg::LenW + 1;
  localparam logic [WideW-1:0] MaxLenW = WideW'(MAX_LEN);
  localparam logic [WideW-1:0] PageW15 = WideW'(PAGE_BYTES);

  sfcp_pkg::op_e                  op_q;
  logic [sfcp_pkg::AddrW-1:0]     addr_q;
  logic [sfcp_pkg::LenW-1:0]      left_q;
  logic [sfcp_pkg::LenW-1:0]      len_clip;
  logic [WideW-1:0]               room;
  logic [sfcp_pkg::LenW-1:0]      chunk;
  logic [sfcp_pkg::LenW-1:0]      rest;
  logic                           out_valid_q;
  sfcp_pkg::desc_t                desc_d, desc_q;

  // length saturation
  assign len_clip = ({1'b0, req_len_i} > MaxLenW) ? MaxLenW[sfcp_pkg::LenW-1:0] : req_len_i;

  // bytes to the end of the current page, limited by what is left
  assign room  = PageW15 - WideW'(addr_q[PageW-1:0]);
  assign chunk = ({1'b0, left_q} < room) ? left_q : room[sfcp_pkg::LenW-1:0];
  assign rest  = left_q - chunk;

  // request registers, advanced per page chunk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= req_op_i;
      addr_q <= req_addr_i;
      left_q <= len_clip;
    end else if (cmd_i.emit) begin
      addr_q <= addr_q + sfcp_pkg::AddrW'(chunk);
      left_q <= rest;
    end
  end

  // descriptor for the current request
  always_comb begin
    desc_d = '0;
    desc_d.last = 1'b1;
    case (op_q)
      sfcp_pkg::OP_READ: begin
        desc_d.command_byte   = sfcp_pkg::CmdRead;
        desc_d.target_address = addr_q;
        desc_d.has_address    = 1'b1;
        desc_d.data_count     = left_q;
        desc_d.data_direction = (left_q != '0) ? sfcp_pkg::DirRead : sfcp_pkg::DirNone;
      end
      sfcp_pkg::OP_WRITE: begin
        desc_d.command_byte   = sfcp_pkg::CmdPage;
        desc_d.target_address = addr_q;
        desc_d.has_address    = 1'b1;
        desc_d.data_count     = chunk;
        desc_d.data_direction = (chunk != '0) ? sfcp_pkg::DirWrite : sfcp_pkg::DirNone;
        desc_d.enable_first   = 1'b1;
        desc_d.poll_after     = 1'b1;
        desc_d.last           = (rest == '0);
      end
      sfcp_pkg::OP_SECTOR: begin
        desc_d.command_byte   = sfcp_pkg::CmdSector;
        desc_d.target_address = addr_q;
        desc_d.has_address    = 1'b1;
        desc_d.enable_first   = 1'b1;
        desc_d.poll_before    = 1'b1;
        desc_d.poll_after     = 1'b1;
      end
      sfcp_pkg::OP_CHIP: begin
        desc_d.command_byte = sfcp_pkg::CmdChip;
        desc_d.enable_first = 1'b1;
        desc_d.poll_after   = 1'b1;
      end
      sfcp_pkg::OP_PWR_DOWN: desc_d.command_byte = sfcp_pkg::CmdPwrDn;
      sfcp_pkg::OP_WAKE:     desc_d.command_byte = sfcp_pkg::CmdWake;
      sfcp_pkg::OP_READ_ID: begin
        desc_d.command_byte   = sfcp_pkg::CmdWake;
        desc_d.dummy_count    = 2'd3;
        desc_d.data_count     = sfcp_pkg::LenW'(1);
        desc_d.data_direction = sfcp_pkg::DirRead;
      end
      default: desc_d.command_byte = sfcp_pkg::CmdWrDis;
    endcase
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) desc_q <= desc_d;
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.last_desc = desc_d.last;
  assign out_valid_o        = out_valid_q;
  assign out_desc_o         = desc_q;

endmodule

// ----- src/spi_flash_command_planner_core.sv -----
// top level of the spi flash command planner
// Takes one flash request word (opcode in tuser, address and length in tdata) and
// emits one SPI transaction descriptor word per chip-select frame, tlast on the
// final one. A request is taken while the planner is idle; the descriptors
// then leave at one per cycle through the output register while the sink
// holds tready high, and a buffer write yields one descriptor per page-program
// chunk. The page split advances one chunk per cycle in the datapath's address
// and remaining-length registers, and stalls while the output register is full.
// PAGE_BYTES must be a power of two.
module spi_flash_command_planner_core #(
  parameter int unsigned PAGE_BYTES = 256,
  parameter int unsigned MAX_LEN    = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [2:0]  s_axis_tuser_i,  // opcode
  input  logic [39:0] s_axis_tdata_i,  // start_address[23:0], byte_length[37:24], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // command_byte, target_address, has_address,
                                       // dummy_count, data_count, data_direction,
                                       // enable_first, poll_before, poll_after, zero pad
  output logic        m_axis_tlast_o
);

  sfcp_pkg::ctrl_cmd_t  cmd;
  sfcp_pkg::dp_status_t status;
  sfcp_pkg::desc_t      desc;

  sfcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfcp_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_LEN    (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_op_i    (sfcp_pkg::op_e'(s_axis_tuser_i)),
    .req_addr_i  (s_axis_tdata_i[23:0]),
    .req_len_i   (s_axis_tdata_i[37:24]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_desc_o  (desc)
  );

  // pack the descriptor word, lowest field first
  assign m_axis_tdata_o = {2'b00, desc.poll_after, desc.poll_before, desc.enable_first,
                           desc.data_direction, desc.data_count, desc.dummy_count,
                           desc.has_address, desc.target_address, desc.command_byte};
  assign m_axis_tlast_o = desc.last;

endmodule

// ----- sim/sfcp_desc_checker.sv -----
// descriptor predictor and scoreboard for the spi flash command planner testbench
module sfcp_desc_checker #(
  parameter int unsigned PAGE_BYTES = 256,
  parameter int unsigned MAX_LEN    = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [2:0]  s_tuser_i,   // opcode
  input  logic [39:0] s_tdata_i,   // start_address, byte_length, zero pad
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,   // descriptor fields without last, zero pad
  input  logic        m_tlast_i,
  output int          mismatch_count_o,
  output int          descs_pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  sfcp_pkg::desc_t planned_descs[$];
  int              bad_descs = 0;

  assign mismatch_count_o = bad_descs;

  // expand one request into the transaction descriptors it must produce
  function automatic void plan_request(sfcp_pkg::op_e op,
                                       logic [sfcp_pkg::AddrW-1:0] addr,
                                       logic [sfcp_pkg::LenW-1:0] len_in);
    sfcp_pkg::desc_t            d;
    int unsigned                remaining;
    int unsigned                chunk;
    int unsigned                rest;
    logic [sfcp_pkg::AddrW-1:0] cur;
    remaining = (len_in > MAX_LEN) ? MAX_LEN : int'(len_in);
    d = '0;
    d.last = 1'b1;
    case (op)
      sfcp_pkg::OP_READ: begin
        d.command_byte   = sfcp_pkg::CmdRead;
        d.target_address = addr;
        d.has_address    = 1'b1;
        d.data_count     = remaining[sfcp_pkg::LenW-1:0];
        d.data_direction = (remaining != 0) ? sfcp_pkg::DirRead : sfcp_pkg::DirNone;
        planned_descs.push_back(d);
      end
      sfcp_pkg::OP_WRITE: begin
        if (remaining == 0) begin
          // empty page program still goes out once
          d.command_byte   = sfcp_pkg::CmdPage;
          d.target_address = addr;
          d.has_address    = 1'b1;
          d.enable_first   = 1'b1;
          d.poll_after     = 1'b1;
          planned_descs.push_back(d);
        end else begin
          // head chunk to the page end, then whole pages, then the tail
          cur   = addr;
          chunk = PAGE_BYTES - (addr % PAGE_BYTES);
          if (chunk > remaining) chunk = remaining;
          while (remaining != 0) begin
            rest             = remaining - chunk;
            d                = '0;
            d.command_byte   = sfcp_pkg::CmdPage;
            d.target_address = cur;
            d.has_address    = 1'b1;
            d.data_count     = chunk[sfcp_pkg::LenW-1:0];
            d.data_direction = sfcp_pkg::DirWrite;
            d.enable_first   = 1'b1;
            d.poll_after     = 1'b1;
            d.last           = (rest == 0);
            planned_descs.push_back(d);
            cur       = cur + chunk[sfcp_pkg::AddrW-1:0];
            remaining = rest;
            chunk     = (remaining < PAGE_BYTES) ? remaining : PAGE_BYTES;
          end
        end
      end
      sfcp_pkg::OP_SECTOR: begin
        d.command_byte   = sfcp_pkg::CmdSector;
        d.target_address = addr;
        d.has_address    = 1'b1;
        d.enable_first   = 1'b1;
        d.poll_before    = 1'b1;
        d.poll_after     = 1'b1;
        planned_descs.push_back(d);
      end
      sfcp_pkg::OP_CHIP: begin
        d.command_byte = sfcp_pkg::CmdChip;
        d.enable_first = 1'b1;
        d.poll_after   = 1'b1;
        planned_descs.push_back(d);
      end
      sfcp_pkg::OP_PWR_DOWN: begin
        d.command_byte = sfcp_pkg::CmdPwrDn;
        planned_descs.push_back(d);
      end
      sfcp_pkg::OP_WAKE: begin
        d.command_byte = sfcp_pkg::CmdWake;
        planned_descs.push_back(d);
      end
      sfcp_pkg::OP_READ_ID: begin
        // wake opcode with three dummy bytes and one id byte back
        d.command_byte   = sfcp_pkg::CmdWake;
        d.dummy_count    = 2'd3;
        d.data_count     = sfcp_pkg::LenW'(1);
        d.data_direction = sfcp_pkg::DirRead;
        planned_descs.push_back(d);
      end
      default: begin
        d.command_byte = sfcp_pkg::CmdWrDis;
        planned_descs.push_back(d);
      end
    endcase
  endfunction

  function automatic string desc_text(sfcp_pkg::desc_t d, logic [1:0] pad);
    return $sformatf({"cmd %h addr %h has_addr %b dummy %0d count %0d dir %0d ",
                      "wren %b poll_pre %b poll_post %b last %b pad %b"},
                     d.command_byte, d.target_address, d.has_address, d.dummy_count,
                     d.data_count, d.data_direction, d.enable_first, d.poll_before,
                     d.poll_after, d.last, pad);
  endfunction

  task automatic report_bad(string what, sfcp_pkg::desc_t want, sfcp_pkg::desc_t got,
                            logic [1:0] pad);
    if (bad_descs < 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", desc_text(want, 2'b00));
      $display("  actual   %s", desc_text(got, pad));
    end
    bad_descs++;
  endtask

  // compare each word leaving the block, then plan each request taken in
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sfcp_pkg::desc_t got;
    sfcp_pkg::desc_t want;
    if (!rst_ni) begin
      planned_descs.delete();
      descs_pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = sfcp_pkg::desc_t'({m_tlast_i, m_tdata_i[53:0]});
        if (planned_descs.size() == 0) begin
          report_bad("descriptor with none expected", '0, got, m_tdata_i[55:54]);
        end else begin
          want = planned_descs.pop_front();
          if (got !== want || m_tdata_i[55:54] !== 2'b00)
            report_bad("descriptor mismatch", want, got, m_tdata_i[55:54]);
        end
      end
      if (s_tvalid_i && s_tready_i)
        plan_request(sfcp_pkg::op_e'(s_tuser_i), s_tdata_i[23:0], s_tdata_i[37:24]);
      descs_pending_o <= planned_descs.size();
    end
  end

endmodule

// ----- sim/tb_spi_flash_command_planner_core.sv -----
// testbench top for the spi flash command planner: request stimulus, sink control, verdict
module tb_spi_flash_command_planner_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PageBytes  = 256;
  localparam int unsigned MaxLen     = 8192;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandomReqs = 242;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser  = '0;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  int   mismatches;
  int   descs_pending;
  logic calm      = 1'b0;  // no idling on either side
  logic long_hold = 1'b0;  // sink holds off for a long stretch once

  spi_flash_command_planner_core #(
    .PAGE_BYTES(PageBytes),
    .MAX_LEN   (MaxLen)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  sfcp_desc_checker #(
    .PAGE_BYTES(PageBytes),
    .MAX_LEN   (MaxLen)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tuser_i       (s_axis_tuser),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .mismatch_count_o(mismatches),
    .descs_pending_o (descs_pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("spi_flash_command_planner_core test failed");
    $finish;
  end

  // sink side: random stall bursts, one long hold-off, none in the calm part
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // offer one request word and hold it until it is taken
  task automatic send_request(input sfcp_pkg::op_e op, input logic [23:0] addr,
                              input logic [13:0] len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, len, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // random source gap after a taken word
  task automatic source_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // source quiet until every planned descriptor has left
  task automatic drain_descs();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (descs_pending != 0);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned   sel;
    sfcp_pkg::op_e op;
    logic [23:0]   addr;
    logic [13:0]   len;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: field extremes, every opcode, page split corners
    send_request(sfcp_pkg::OP_READ,     24'h000000, 14'd0);     source_gap();
    send_request(sfcp_pkg::OP_READ,     24'hFFFFFF, 14'd8192);  source_gap();
    send_request(sfcp_pkg::OP_READ,     24'h123456, 14'h3FFF);  source_gap();
    send_request(sfcp_pkg::OP_READ,     24'hABCDEF, 14'd1);     source_gap();
    send_request(sfcp_pkg::OP_READ,     24'h000000, 14'd8193);  source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h000010, 14'd0);     source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h000100, 14'd512);   source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h0000F0, 14'd300);   source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'hFFFFF0, 14'd40);    source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'hFFFF80, 14'h3FFF);  source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h000000, 14'd8192);  source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h0000FF, 14'd1);     source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'h3FFF00, 14'd256);   source_gap();
    send_request(sfcp_pkg::OP_WRITE,    24'hFFFF00, 14'd8191);  source_gap();
    send_request(sfcp_pkg::OP_SECTOR,   24'h7654AB, 14'h2AAA);  source_gap();
    send_request(sfcp_pkg::OP_SECTOR,   24'hFFFFFF, 14'h3FFF);  source_gap();
    send_request(sfcp_pkg::OP_CHIP,     24'hFFFFFF, 14'h3FFF);  source_gap();
    send_request(sfcp_pkg::OP_PWR_DOWN, 24'h5A5A5A, 14'd100);   source_gap();
    send_request(sfcp_pkg::OP_WAKE,     24'h000000, 14'd0);     source_gap();
    send_request(sfcp_pkg::OP_READ_ID,  24'hFFFFFF, 14'h3FFF);  source_gap();
    send_request(sfcp_pkg::OP_WR_DIS,   24'h000001, 14'd5);     source_gap();
    send_request(sfcp_pkg::OP_WAKE,     24'hA5A5A5, 14'h1555);
    drain_descs();

    // back pressure: sink holds off while requests keep coming
    long_hold = 1'b1;
    repeat (16) begin
      send_request(sfcp_pkg::OP_WRITE, 24'($urandom), 14'($urandom_range(1, 700)));
    end
    drain_descs();

    // random requests, mostly writes with small lengths
    for (int i = 0; i < RandomReqs; i++) begin
      calm = (i >= RandomReqs - 40);
      sel  = $urandom_range(0, 99);
      if (sel < 45)      op = sfcp_pkg::OP_WRITE;
      else if (sel < 60) op = sfcp_pkg::OP_READ;
      else               op = sfcp_pkg::op_e'(3'($urandom_range(0, 7)));
      case ($urandom_range(0, 9))
        0, 1:    addr = {16'($urandom), 8'h00};
        2:       addr = {16'hFFFF, 8'($urandom)};
        3:       addr = {16'($urandom), 8'($urandom_range(8'hF0, 8'hFF))};
        default: addr = 24'($urandom);
      endcase
      case ($urandom_range(0, 19))
        0:       len = 14'd0;
        1:       len = 14'($urandom_range(8190, 16383));
        2:       len = 14'($urandom_range(257, 8192));
        3:       len = {6'($urandom_range(1, 8)), 8'h00};
        default: len = 14'($urandom_range(1, 600));
      endcase
      send_request(op, addr, len);
      source_gap();
    end
    drain_descs();
    repeat (40) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("spi_flash_command_planner_core test passed");
    end else begin
      $display("spi_flash_command_planner_core test failed");
    end
    $finish;
  end

endmodule

// ----- spi_flash_command_planner_core.f -----
src/sfcp_pkg.sv
src/sfcp_ctrl.sv
src/sfcp_dp.sv
src/spi_flash_command_planner_core.sv
sim/sfcp_desc_checker.sv
sim/tb_spi_flash_command_planner_core.sv
